FILE: rtl/core/q24_pkg.sv
// Package for the Q24.8 fixed-point unit: codes, widths and result record.
package q24_pkg;

  localparam int FracBits = 8;
  localparam int WordBits = 32;
  localparam int QuoBits  = WordBits + FracBits + 1;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
    FN_GT  = 4'd4, FN_LT  = 4'd5, FN_GE  = 4'd6, FN_LE  = 4'd7,
    FN_EQ  = 4'd8, FN_NE  = 4'd9, FN_MIN = 4'd10, FN_MAX = 4'd11,
    FN_INC = 4'd12, FN_DEC = 4'd13, FN_TOINT = 4'd14, FN_NONE = 4'd15
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    logic [WordBits-1:0] value;
    logic                cmp;
    status_t             status;
  } result_t;

endpackage

FILE: rtl/core/q24_div.sv
// Pipelined restoring divider: one quotient bit per stage, rounded half away from zero.
module q24_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [q24_pkg::WordBits-1:0]      dividend,
  input  logic [q24_pkg::WordBits-1:0]      divisor,
  output logic                              out_valid,
  output logic [q24_pkg::QuoBits-1:0]       quotient
);
  localparam int W = q24_pkg::WordBits;
  localparam int N = W + q24_pkg::FracBits;

  // Per-stage numerator bits, partial remainder, divisor and quotient.
  logic [N-1:0] num [0:N];
  logic [W:0]   rem [0:N];
  logic [W-1:0] dvs [0:N];
  logic [N-1:0] quo [0:N];
  logic         vld [0:N];

  always_comb begin
    num[0] = {dividend, {q24_pkg::FracBits{1'b0}}};
    rem[0] = '0;
    dvs[0] = divisor;
    quo[0] = '0;
    vld[0] = in_valid;
  end

  // Each stage shifts in one numerator bit and tries a subtraction.
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [W:0] trial;
    logic       fits;
    always_comb begin
      trial = {rem[s][W-1:0], num[s][N-1]};
      fits  = trial >= {1'b0, dvs[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        num[s+1] <= num[s] << 1;
        rem[s+1] <= fits ? trial - {1'b0, dvs[s]} : trial;
        dvs[s+1] <= dvs[s];
        quo[s+1] <= {quo[s][N-2:0], fits};
      end
    end
  end

  // Round up when the remainder is at least half of the divisor.
  logic round_up;
  always_comb begin
    round_up  = ({1'b0, dvs[N]} - rem[N]) <= rem[N];
    quotient  = {1'b0, quo[N]} + {{(q24_pkg::QuoBits-1){1'b0}}, round_up};
    out_valid = vld[N];
  end
endmodule

FILE: rtl/core/q24_8_fixed_point_alu_top.sv
// Top level of the Q24.8 fixed-point unit.
// Signed Q24.8 arithmetic unit: add, subtract, multiply and divide rounded half away
// from zero, with saturation (status 1) and divide by zero (status 2, result 0), plus
// compares, min/max, inc/dec and to_int. It is a 42-stage pipeline that accepts one
// transfer per clock when not stalled; the divider, which resolves one quotient bit
// per stage, sets its depth. All operations take the same stages, so results keep
// order. It stalls as a whole whenever the output holds a result that is not taken.
module q24_8_fixed_point_alu_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // func[3:0], operand_a[35:4], operand_b[67:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_value[31:0], compare_true[32], status[34:33]
);
  localparam int W   = q24_pkg::WordBits;
  localparam int F   = q24_pkg::FracBits;
  localparam int Q   = q24_pkg::QuoBits;
  localparam int LAT = W + F;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic                acc;
  q24_pkg::func_t      fn;
  logic signed [W-1:0] a, b;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign fn  = q24_pkg::func_t'(s_axis_tdata[3:0]);
  assign a   = s_axis_tdata[35:4];
  assign b   = s_axis_tdata[67:36];

  function automatic q24_pkg::result_t sat(input logic [W:0] s);
    q24_pkg::result_t r;
    r = '{value: s[W-1:0], cmp: 1'b0, status: q24_pkg::ST_OK};
    if (s[W] != s[W-1]) begin
      r.status = q24_pkg::ST_OVF;
      r.value  = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  // Sign a magnitude and saturate it to the word range.
  function automatic q24_pkg::result_t signmag(input logic [Q-1:0] m, input logic n);
    q24_pkg::result_t r;
    logic [Q-1:0] lim;
    lim = n ? (Q'(1) << (W-1)) : ((Q'(1) << (W-1)) - Q'(1));
    r = '{value: '0, cmp: 1'b0, status: q24_pkg::ST_OK};
    if (m > lim) begin
      r.status = q24_pkg::ST_OVF;
      r.value  = n ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r.value = n ? -m[W-1:0] : m[W-1:0];
    end
    return r;
  endfunction

  // Stage one: magnitudes, signs and the simple operations.
  logic [W-1:0] ma, mb;
  logic         neg;
  q24_pkg::result_t simple;
  logic [W:0]   sum, dif, inc, dec;
  logic         lt, gt;
  always_comb begin
    ma  = a[W-1] ? -a : a;
    mb  = b[W-1] ? -b : b;
    neg = a[W-1] ^ b[W-1];
    lt  = a < b;
    gt  = b < a;
    sum = {a[W-1], a} + {b[W-1], b};
    dif = {a[W-1], a} - {b[W-1], b};
    inc = {a[W-1], a} + (W+1)'(1);
    dec = {a[W-1], a} - (W+1)'(1);
    simple = '{value: '0, cmp: 1'b0, status: q24_pkg::ST_OK};
    case (fn)
      q24_pkg::FN_ADD: simple = sat(sum);
      q24_pkg::FN_SUB: simple = sat(dif);
      q24_pkg::FN_INC: simple = sat(inc);
      q24_pkg::FN_DEC: simple = sat(dec);
      q24_pkg::FN_GT:  simple.cmp = gt;
      q24_pkg::FN_LT:  simple.cmp = lt;
      q24_pkg::FN_GE:  simple.cmp = !lt;
      q24_pkg::FN_LE:  simple.cmp = !gt;
      q24_pkg::FN_EQ:  simple.cmp = a == b;
      q24_pkg::FN_NE:  simple.cmp = a != b;
      q24_pkg::FN_MIN: simple.value = lt ? a : b;
      q24_pkg::FN_MAX: simple.value = gt ? a : b;
      q24_pkg::FN_TOINT: simple.value = W'(a >>> F);
      default: ;
    endcase
  end

  // Side channel that travels alongside the divider.
  typedef struct packed {
    q24_pkg::func_t   fn;
    logic             neg;
    logic             bzero;
    q24_pkg::result_t simple;
    logic [W-1:0]     ma;
    logic [W-1:0]     mb;
    logic [2*W-1:0]   prod;
  } side_t;

  side_t side [0:LAT];
  logic  vld  [0:LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= acc;
    end
    if (en) begin
      side[0] <= '{fn: fn, neg: neg, bzero: b == '0, simple: simple,
                   ma: ma, mb: mb, prod: '0};
    end
  end

  // Multiplier: 32x32 product registered in stage two, rounded later.
  side_t mul_side;
  always_comb begin
    mul_side      = side[0];
    mul_side.prod = side[0].ma * side[0].mb;
  end

  for (genvar s = 0; s < LAT; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        side[s+1] <= (s == 0) ? mul_side : side[s];
      end
    end
  end

  logic         dv;
  logic [Q-1:0] quo;
  q24_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vld[0]),
    .dividend(side[0].ma), .divisor(side[0].mb),
    .out_valid(dv), .quotient(quo)
  );

  // Final stage: pick the result for the operation.
  side_t            f;
  logic [2*W-1:0]   pr;
  q24_pkg::result_t fin;
  always_comb begin
    f  = side[LAT];
    pr = (f.prod + (2*W)'(1 << (F-1))) >> F;
    fin = f.simple;
    case (f.fn)
      q24_pkg::FN_MUL: fin = signmag(pr[Q-1:0] | {Q{|pr[2*W-1:Q]}}, f.neg);
      q24_pkg::FN_DIV: fin = f.bzero ? '{value: '0, cmp: 1'b0, status: q24_pkg::ST_DIV0}
                                     : signmag(quo, f.neg);
      default: ;
    endcase
  end

  logic [39:0] odata;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld[LAT] && dv;
    end
    if (en) begin
      odata <= {5'd0, fin.status, fin.cmp, fin.value};
    end
  end
  assign m_axis_tdata = odata;
endmodule

FILE: test/tb_q24_8_fixed_point_alu_top.sv
// Testbench for the Q24.8 fixed-point unit: random and directed operations checked in order.
module tb_q24_8_fixed_point_alu_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  status;
  } alu_out_t;

  // Expected-result store with its own arithmetic predictor.
  class alu_scoreboard;
    alu_out_t pending[$];
    int errors;

    function logic [31:0] saturate(logic signed [127:0] v, inout logic [1:0] st);
      if (v > 128'sh7FFFFFFF) begin
        st = q24_pkg::ST_OVF;
        return 32'h7FFFFFFF;
      end
      if (v < -128'sh80000000) begin
        st = q24_pkg::ST_OVF;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    function alu_out_t compute(q24_pkg::func_t f, logic signed [31:0] a,
                               logic signed [31:0] b);
      alu_out_t r;
      logic signed [127:0] wa, wb, v;
      logic [127:0] ma, mb, q, rem;
      logic neg;
      wa = a;
      wb = b;
      ma = (a < 0) ? -wa : wa;
      mb = (b < 0) ? -wb : wb;
      neg = (a < 0) != (b < 0);
      r.value = '0;
      r.cmp = 1'b0;
      r.status = q24_pkg::ST_OK;
      case (f)
        q24_pkg::FN_ADD: r.value = saturate(wa + wb, r.status);
        q24_pkg::FN_SUB: r.value = saturate(wa - wb, r.status);
        q24_pkg::FN_MUL: begin
          q = (ma * mb + 128'd128) >> q24_pkg::FracBits;
          v = neg ? -$signed(q) : $signed(q);
          r.value = saturate(v, r.status);
        end
        q24_pkg::FN_DIV: begin
          if (b == 0) begin
            r.status = q24_pkg::ST_DIV0;
          end else begin
            q = (ma << q24_pkg::FracBits) / mb;
            rem = (ma << q24_pkg::FracBits) % mb;
            if (mb - rem <= rem) q = q + 1;
            v = neg ? -$signed(q) : $signed(q);
            r.value = saturate(v, r.status);
          end
        end
        q24_pkg::FN_GT: r.cmp = a > b;
        q24_pkg::FN_LT: r.cmp = a < b;
        q24_pkg::FN_GE: r.cmp = a >= b;
        q24_pkg::FN_LE: r.cmp = a <= b;
        q24_pkg::FN_EQ: r.cmp = a == b;
        q24_pkg::FN_NE: r.cmp = a != b;
        q24_pkg::FN_MIN: r.value = (a < b) ? a : b;
        q24_pkg::FN_MAX: r.value = (b < a) ? a : b;
        q24_pkg::FN_INC: r.value = saturate(wa + 1, r.status);
        q24_pkg::FN_DEC: r.value = saturate(wa - 1, r.status);
        q24_pkg::FN_TOINT: r.value = a >>> q24_pkg::FracBits;
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(logic [71:0] d);
      pending.push_back(compute(q24_pkg::func_t'(d[3:0]), d[35:4], d[67:36]));
    endfunction

    function void check_result(logic [39:0] d);
      alu_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.value) begin
        $error("result_value expected %h actual %h", e.value, d[31:0]);
        errors++;
      end
      if (d[32] !== e.cmp) begin
        $error("compare_true expected %b actual %b", e.cmp, d[32]);
        errors++;
      end
      if (d[34:33] !== e.status) begin
        $error("status expected %0d actual %0d", e.status, d[34:33]);
        errors++;
      end
    endfunction
  endclass

  localparam int NumRandom = 350;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  alu_scoreboard board = new();
  bit sending_done = 1'b0;
  bit long_hold = 1'b0;
  int cycles = 0;

  q24_8_fixed_point_alu_top DUT (.*);

  always #5 clk = ~clk;

  // Count cycles and stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Log every transfer on both sides at the rising edge.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) board.note_input(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return '0;
      3: return $urandom_range(0, 4095) - 2048;
      4: return $urandom_range(0, 1 << 20) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(logic [3:0] f, logic [31:0] a, logic [31:0] b, bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) wait_cycles = 0;
    if (wait_cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, b, a, f};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender: directed corners, then random traffic.
  initial begin
    logic [3:0] f;
    logic [31:0] a;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    send_item(q24_pkg::FN_ADD, 32'h7FFFFFFF, 32'h00000001, 1'b0);
    send_item(q24_pkg::FN_ADD, 32'h80000000, 32'hFFFFFFFF, 1'b0);
    send_item(q24_pkg::FN_SUB, 32'h80000000, 32'h00000001, 1'b0);
    send_item(q24_pkg::FN_SUB, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
    send_item(q24_pkg::FN_MUL, 32'h00000180, 32'hFFFFFE80, 1'b0);
    send_item(q24_pkg::FN_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    send_item(q24_pkg::FN_MUL, 32'h80000000, 32'h80000000, 1'b0);
    send_item(q24_pkg::FN_MUL, 32'h00000001, 32'h00000080, 1'b0);
    send_item(q24_pkg::FN_MUL, 32'hFFFFFFFF, 32'h00000080, 1'b0);
    send_item(q24_pkg::FN_DIV, 32'h00000100, 32'h00000300, 1'b0);
    send_item(q24_pkg::FN_DIV, 32'h80000000, 32'h00000001, 1'b0);
    send_item(q24_pkg::FN_DIV, 32'h80000000, 32'hFFFFFFFF, 1'b0);
    send_item(q24_pkg::FN_DIV, 32'h12345678, 32'h00000000, 1'b0);
    send_item(q24_pkg::FN_DIV, 32'hFFFFFF80, 32'h00000100, 1'b0);
    send_item(q24_pkg::FN_GT, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_item(q24_pkg::FN_LT, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_item(q24_pkg::FN_GE, 32'h00000005, 32'h00000005, 1'b0);
    send_item(q24_pkg::FN_LE, 32'h00000006, 32'h00000005, 1'b0);
    send_item(q24_pkg::FN_EQ, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    send_item(q24_pkg::FN_NE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    send_item(q24_pkg::FN_MIN, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_item(q24_pkg::FN_MAX, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_item(q24_pkg::FN_INC, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
    send_item(q24_pkg::FN_DEC, 32'h80000000, 32'h00000000, 1'b0);
    send_item(q24_pkg::FN_TOINT, 32'hFFFFFEFF, 32'h00000000, 1'b0);
    send_item(q24_pkg::FN_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    // Back-to-back burst while the receiver holds off, so the pipeline fills.
    long_hold = 1'b1;
    repeat (80) send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand(), 1'b0);
    long_hold = 1'b0;
    for (int i = 0; i < NumRandom; i++) begin
      f = 4'($urandom_range(0, 15));
      a = pick_operand();
      send_item(f, a, ($urandom_range(0, 9) == 0) ? a : pick_operand(), i % 100 >= 30);
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off during the burst.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (150) @(negedge clk);
      end
      stall = (cycles % 3000 < 800) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Wait for the tail of the pipeline, then report.
  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/q24_pkg.sv
rtl/core/q24_div.sv
rtl/core/q24_8_fixed_point_alu_top.sv
test/tb_q24_8_fixed_point_alu_top.sv
